// ===== hdl/trd_pkg.sv =====
// Shared types and constants for the triangle raster / depth test core.
// Holds the input item, queued command and sequencer types, plus fixed widths.
// No dependencies.
package trd_pkg;

	localparam int MAX_WIDTH  = 128;
	localparam int MAX_HEIGHT = 128;
	localparam int SUB_BITS   = 4;
	localparam int DEPTH_BITS = 16;
	localparam int COLOR_W    = 24;
	localparam int CW         = 16;              // input coordinate width
	localparam int VW         = CW + 1;          // doubled coordinate
	localparam int DW         = VW + 1;          // difference of doubled coordinates
	localparam int PW         = 2 * DW;          // edge partial product
	localparam int EW         = PW + 2;          // edge value
	localparam int AW         = EW;              // area magnitude / weights
	localparam int NW         = AW + DEPTH_BITS; // depth numerator
	localparam int STEP_SH    = SUB_BITS + 1;    // one pixel in doubled subpixel units
	localparam int SW         = DW + STEP_SH;    // edge increment per pixel
	localparam int FW         = CW - SUB_BITS;   // integer pixel part
	localparam int DIM_W      = 8;
	localparam int PIX_W      = 2 * DIM_W;
	localparam int CNT_W      = $clog2(DEPTH_BITS);

	localparam logic [DEPTH_BITS-1:0] DEPTH_FAR = {DEPTH_BITS{1'b1}};

	typedef enum logic [1:0] {
		KIND_DRAW  = 2'd0,
		KIND_CLEAR = 2'd1,
		KIND_READ  = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} reg_idx_t;

	typedef logic signed [EW-1:0] edge_t;
	typedef logic signed [SW-1:0] step_t;

	typedef struct packed {
		kind_t                  kind;
		logic signed [CW-1:0]   x0;
		logic signed [CW-1:0]   y0;
		logic [CW-1:0]          z0;
		logic signed [CW-1:0]   x1;
		logic signed [CW-1:0]   y1;
		logic [CW-1:0]          z1;
		logic signed [CW-1:0]   x2;
		logic signed [CW-1:0]   y2;
		logic [CW-1:0]          z2;
		logic [COLOR_W-1:0]     fill_color;
		logic [1:0]             clear_mask;
	} item_t;

	typedef struct packed {
		kind_t                  kind;
		edge_t                  e0;
		edge_t                  e1;
		edge_t                  e2;
		step_t                  dx0;
		step_t                  dx1;
		step_t                  dx2;
		step_t                  dy0;
		step_t                  dy1;
		step_t                  dy2;
		logic [AW-1:0]          amag;
		logic [DIM_W-1:0]       lox;
		logic [DIM_W-1:0]       hix;
		logic [DIM_W-1:0]       loy;
		logic [DIM_W-1:0]       hiy;
		logic [DEPTH_BITS-1:0]  z0;
		logic [DEPTH_BITS-1:0]  z1;
		logic [DEPTH_BITS-1:0]  z2;
		logic [COLOR_W-1:0]     color;
		logic [1:0]             mask;
		logic                   rd_ok;
		logic [PIX_W-1:0]       rd_addr;
	} cmd_t;

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_SCAN,
		ST_MUL,
		ST_SUM,
		ST_DIV,
		ST_CMP,
		ST_RDW,
		ST_ROUT
	} back_state_t;

	function automatic logic signed [FW-1:0] floor_px(input logic signed [CW-1:0] v);
		logic signed [CW-1:0] s;
		s = v >>> SUB_BITS;
		floor_px = FW'(s);
	endfunction

endpackage

// ===== hdl/trd_front.sv =====
// Front end: accepts items, clips bounding boxes, sets up edge equations.
// Three register stages; drops empty or degenerate draws and unknown kinds.
// Depends on trd_pkg.
module trd_front (
	input  logic             clk,
	input  logic             arst_n,
	input  trd_pkg::item_t   item,
	input  logic             item_valid,
	output logic             item_ready,
	input  logic [7:0]       eff_w,
	input  logic [7:0]       eff_h,
	output trd_pkg::cmd_t    cmd,
	output logic             cmd_push,
	input  logic             q_full
);
	import trd_pkg::*;

	localparam int FW1 = FW + 1;

	logic adv;
	logic v_s1, v_s2, v_s3;

	// stage 1 combinational
	logic signed [CW-1:0]  mnx, mxx, mny, mxy;
	logic signed [FW1-1:0] lo_x, hi_x, lo_y, hi_y, wm1, hm1, fmnx, fmxx, fmny, fmxy;
	logic signed [FW1-1:0] rpx, rpy;
	logic                  empty_c, rdok_c;

	kind_t                  kind_s1, kind_s2, kind_s3;
	logic signed [VW-1:0]   vx_s1 [3];
	logic signed [VW-1:0]   vy_s1 [3];
	logic [DEPTH_BITS-1:0]  z_s1 [3];
	logic [DEPTH_BITS-1:0]  z_s2 [3];
	logic [DEPTH_BITS-1:0]  z_s3 [3];
	logic [COLOR_W-1:0]     color_s1, color_s2, color_s3;
	logic [1:0]             mask_s1, mask_s2, mask_s3;
	logic [DIM_W-1:0]       lox_s1, hix_s1, loy_s1, hiy_s1;
	logic [DIM_W-1:0]       lox_s2, hix_s2, loy_s2, hiy_s2;
	logic [DIM_W-1:0]       lox_s3, hix_s3, loy_s3, hiy_s3;
	logic                   empty_s1, empty_s2, empty_s3;
	logic                   rdok_s1, rdok_s2, rdok_s3;
	logic [DIM_W-1:0]       rpx_s1, rpy_s1;
	logic [PIX_W-1:0]       raddr_s2, raddr_s3;

	logic signed [PW-1:0]   pa_s2 [3];
	logic signed [PW-1:0]   pb_s2 [3];
	step_t                  dx_s2 [3];
	step_t                  dy_s2 [3];
	step_t                  dx_s3 [3];
	step_t                  dy_s3 [3];
	edge_t                  e_s3 [3];

	logic signed [DW-1:0]   cx, cy;
	edge_t                  area;
	logic                   keep;

	always_comb begin
		mnx = item.x0;
		mxx = item.x0;
		mny = item.y0;
		mxy = item.y0;
		if (item.x1 < mnx) mnx = item.x1;
		if (item.x2 < mnx) mnx = item.x2;
		if (item.x1 > mxx) mxx = item.x1;
		if (item.x2 > mxx) mxx = item.x2;
		if (item.y1 < mny) mny = item.y1;
		if (item.y2 < mny) mny = item.y2;
		if (item.y1 > mxy) mxy = item.y1;
		if (item.y2 > mxy) mxy = item.y2;
		fmnx = FW1'(floor_px(mnx));
		fmxx = FW1'(floor_px(mxx));
		fmny = FW1'(floor_px(mny));
		fmxy = FW1'(floor_px(mxy));
		wm1  = $signed({{(FW1-DIM_W){1'b0}}, eff_w}) - FW1'(1);
		hm1  = $signed({{(FW1-DIM_W){1'b0}}, eff_h}) - FW1'(1);
		lo_x = (fmnx < 0) ? '0 : fmnx;
		lo_y = (fmny < 0) ? '0 : fmny;
		hi_x = (fmxx > wm1) ? wm1 : fmxx;
		hi_y = (fmxy > hm1) ? hm1 : fmxy;
		empty_c = (hi_x < lo_x) || (hi_y < lo_y);
		rpx = FW1'(floor_px(item.x0));
		rpy = FW1'(floor_px(item.y0));
		rdok_c = (rpx >= 0) && (rpy >= 0) && (rpx <= wm1) && (rpy <= hm1);
	end

	// stage 3 push decision
	always_comb begin
		area = e_s3[0] + e_s3[1] + e_s3[2];
		keep = (kind_s3 != KIND_DRAW) || (!empty_s3 && area != '0);
		cmd_push = v_s3 && keep && !q_full;
		adv = !(v_s3 && keep && q_full);
		item_ready = adv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= item_valid && (item.kind != KIND_NONE);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1  <= item.kind;
			vx_s1[0] <= VW'(item.x0) <<< 1;
			vx_s1[1] <= VW'(item.x1) <<< 1;
			vx_s1[2] <= VW'(item.x2) <<< 1;
			vy_s1[0] <= VW'(item.y0) <<< 1;
			vy_s1[1] <= VW'(item.y1) <<< 1;
			vy_s1[2] <= VW'(item.y2) <<< 1;
			z_s1[0]  <= item.z0;
			z_s1[1]  <= item.z1;
			z_s1[2]  <= item.z2;
			color_s1 <= item.fill_color;
			mask_s1  <= item.clear_mask;
			lox_s1   <= DIM_W'(lo_x);
			hix_s1   <= DIM_W'(hi_x);
			loy_s1   <= DIM_W'(lo_y);
			hiy_s1   <= DIM_W'(hi_y);
			empty_s1 <= empty_c;
			rdok_s1  <= rdok_c;
			rpx_s1   <= DIM_W'(rpx);
			rpy_s1   <= DIM_W'(rpy);

			kind_s2  <= kind_s1;
			z_s2     <= z_s1;
			color_s2 <= color_s1;
			mask_s2  <= mask_s1;
			lox_s2   <= lox_s1;
			hix_s2   <= hix_s1;
			loy_s2   <= loy_s1;
			hiy_s2   <= hiy_s1;
			empty_s2 <= empty_s1;
			rdok_s2  <= rdok_s1;
			raddr_s2 <= (PIX_W'(eff_h) - PIX_W'(1) - PIX_W'(rpy_s1)) * PIX_W'(eff_w)
				+ PIX_W'(rpx_s1);

			kind_s3  <= kind_s2;
			z_s3     <= z_s2;
			color_s3 <= color_s2;
			mask_s3  <= mask_s2;
			lox_s3   <= lox_s2;
			hix_s3   <= hix_s2;
			loy_s3   <= loy_s2;
			hiy_s3   <= hiy_s2;
			empty_s3 <= empty_s2;
			rdok_s3  <= rdok_s2;
			raddr_s3 <= raddr_s2;
			dx_s3    <= dx_s2;
			dy_s3    <= dy_s2;
		end
	end

	// pixel center of the box corner, doubled coordinates
	assign cx = $signed(DW'({lox_s1, 1'b1}) << SUB_BITS);
	assign cy = $signed(DW'({loy_s1, 1'b1}) << SUB_BITS);

	for (genvar i = 0; i < 3; i++) begin : g_edge
		localparam int A = (i + 1) % 3;
		localparam int B = (i + 2) % 3;
		logic signed [DW-1:0] ex, ey, ox, oy;
		assign ex = DW'(vx_s1[B]) - DW'(vx_s1[A]);
		assign ey = DW'(vy_s1[B]) - DW'(vy_s1[A]);
		assign ox = cx - DW'(vx_s1[A]);
		assign oy = cy - DW'(vy_s1[A]);
		always_ff @(posedge clk) begin
			if (adv) begin
				pa_s2[i] <= ex * oy;
				pb_s2[i] <= ey * ox;
				dy_s2[i] <= SW'(ex) <<< STEP_SH;
				dx_s2[i] <= -(SW'(ey) <<< STEP_SH);
				e_s3[i]  <= EW'(pa_s2[i]) - EW'(pb_s2[i]);
			end
		end
	end

	always_comb begin
		cmd.kind    = kind_s3;
		cmd.e0      = e_s3[0];
		cmd.e1      = e_s3[1];
		cmd.e2      = e_s3[2];
		cmd.dx0     = dx_s3[0];
		cmd.dx1     = dx_s3[1];
		cmd.dx2     = dx_s3[2];
		cmd.dy0     = dy_s3[0];
		cmd.dy1     = dy_s3[1];
		cmd.dy2     = dy_s3[2];
		cmd.amag    = (area < 0) ? AW'(-area) : AW'(area);
		cmd.lox     = lox_s3;
		cmd.hix     = hix_s3;
		cmd.loy     = loy_s3;
		cmd.hiy     = hiy_s3;
		cmd.z0      = z_s3[0];
		cmd.z1      = z_s3[1];
		cmd.z2      = z_s3[2];
		cmd.color   = color_s3;
		cmd.mask    = mask_s3;
		cmd.rd_ok   = rdok_s3;
		cmd.rd_addr = raddr_s3;
	end

endmodule

// ===== hdl/trd_queue.sv =====
// Two-entry command queue between front end and back end.
// Depends on trd_pkg.
module trd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  trd_pkg::cmd_t  wr_data,
	input  logic           push,
	output logic           full,
	output trd_pkg::cmd_t  rd_data,
	input  logic           pop,
	output logic           empty
);
	import trd_pkg::*;

	cmd_t       slot_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign rd_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hdl/trd_back.sv =====
// Back end: scans pixels, interpolates depth with a bit-serial divider,
// runs the depth test against the stores, sweeps clears and serves reads.
// Depends on trd_pkg.
module trd_back #(
	parameter int STORE_SIZE = 16384
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  trd_pkg::cmd_t                      cmd,
	input  logic                               q_empty,
	output logic                               q_pop,
	input  logic [7:0]                         eff_w,
	input  logic [7:0]                         eff_h,
	output logic                               init_done,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [trd_pkg::COLOR_W-1:0]        out_color,
	output logic [trd_pkg::DEPTH_BITS-1:0]     out_depth
);
	import trd_pkg::*;

	localparam int ADDR_W = $clog2(STORE_SIZE);

	back_state_t state_q, state_d;

	cmd_t                  cmd_q;
	edge_t                 e_q [3];
	edge_t                 ecol_q [3];
	edge_t                 dxe [3];
	edge_t                 dye [3];
	logic [AW-1:0]         w_q [3];
	logic [NW-1:0]         prod_q [3];
	logic [DEPTH_BITS-1:0] zc [3];
	logic [DIM_W-1:0]      px_q, py_q;
	logic [AW-1:0]         rem_q, rem_d;
	logic [DEPTH_BITS-1:0] lo_q, quo_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [PIX_W-1:0]      addr_q;
	logic [ADDR_W-1:0]     clr_q;
	logic [1:0]            mask_q;
	logic                  init_q;
	logic                  out_v_q;
	logic [COLOR_W-1:0]    out_c_q;
	logic [DEPTH_BITS-1:0] out_d_q;

	logic [DEPTH_BITS-1:0] depth_mem [STORE_SIZE];
	logic [COLOR_W-1:0]    color_mem [STORE_SIZE];
	logic [DEPTH_BITS-1:0] depth_rd;
	logic [COLOR_W-1:0]    color_rd;

	logic                  covered, last_row, last_col, clr_last, addr_ok, hit, slot_free;
	logic [AW:0]           div_t;
	logic                  div_ge;
	logic [NW-1:0]         num;
	logic                  we_d, we_c;
	logic [ADDR_W-1:0]     wa, ra;
	logic [DEPTH_BITS-1:0] wd_d;
	logic [COLOR_W-1:0]    wd_c;

	assign dxe[0] = EW'(cmd_q.dx0);
	assign dxe[1] = EW'(cmd_q.dx1);
	assign dxe[2] = EW'(cmd_q.dx2);
	assign dye[0] = EW'(cmd_q.dy0);
	assign dye[1] = EW'(cmd_q.dy1);
	assign dye[2] = EW'(cmd_q.dy2);
	assign zc[0]  = cmd_q.z0;
	assign zc[1]  = cmd_q.z1;
	assign zc[2]  = cmd_q.z2;

	always_comb begin
		covered  = (e_q[0] > 0 && e_q[1] > 0 && e_q[2] > 0) ||
			(e_q[0] < 0 && e_q[1] < 0 && e_q[2] < 0);
		last_row = (py_q == cmd_q.hiy);
		last_col = (px_q == cmd_q.hix);
		clr_last = (clr_q == ADDR_W'(STORE_SIZE - 1));
		addr_ok  = (32'(addr_q) < 32'(STORE_SIZE));
		hit      = addr_ok && (quo_q <= depth_rd);
		slot_free = !out_v_q || out_ready;
		div_t    = {rem_q, lo_q[DEPTH_BITS-1]};
		div_ge   = (div_t >= {1'b0, cmd_q.amag});
		rem_d    = div_ge ? AW'(div_t - {1'b0, cmd_q.amag}) : div_t[AW-1:0];
		num      = prod_q[0] + prod_q[1] + prod_q[2] + NW'(cmd_q.amag >> 1);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLR:  if (clr_last) state_d = ST_IDLE;
			ST_IDLE: begin
				if (!q_empty) begin
					unique case (cmd.kind)
						KIND_DRAW:  state_d = ST_SCAN;
						KIND_CLEAR: state_d = ST_CLR;
						KIND_READ:  state_d = ST_RDW;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_SCAN: begin
				if (covered) state_d = ST_MUL;
				else if (last_row && last_col) state_d = ST_IDLE;
			end
			ST_MUL:  state_d = ST_SUM;
			ST_SUM:  state_d = ST_DIV;
			ST_DIV:  if (cnt_q == CNT_W'(DEPTH_BITS - 1)) state_d = ST_CMP;
			ST_CMP:  state_d = (last_row && last_col) ? ST_IDLE : ST_SCAN;
			ST_RDW:  state_d = ST_ROUT;
			ST_ROUT: if (slot_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		q_pop = (state_q == ST_IDLE) && !q_empty;
		we_d  = ((state_q == ST_CLR) && mask_q[1]) || ((state_q == ST_CMP) && hit);
		we_c  = ((state_q == ST_CLR) && mask_q[0]) || ((state_q == ST_CMP) && hit);
		wa    = (state_q == ST_CLR) ? clr_q : ADDR_W'(addr_q);
		ra    = ADDR_W'(addr_q);
		wd_d  = (state_q == ST_CLR) ? DEPTH_FAR : quo_q;
		wd_c  = (state_q == ST_CLR) ? '0 : cmd_q.color;
	end

	always_ff @(posedge clk) begin
		if (we_d) depth_mem[wa] <= wd_d;
		depth_rd <= depth_mem[ra];
	end

	always_ff @(posedge clk) begin
		if (we_c) color_mem[wa] <= wd_c;
		color_rd <= color_mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			init_q  <= 1'b0;
			clr_q   <= '0;
			mask_q  <= 2'b11;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLR) begin
				clr_q <= clr_q + ADDR_W'(1);
				if (clr_last) init_q <= 1'b1;
			end
			if (q_pop) begin
				clr_q  <= '0;
				mask_q <= cmd.mask;
			end
			if (state_q == ST_ROUT && slot_free) out_v_q <= 1'b1;
			else if (out_ready) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					cmd_q     <= cmd;
					e_q[0]    <= cmd.e0;
					e_q[1]    <= cmd.e1;
					e_q[2]    <= cmd.e2;
					ecol_q[0] <= cmd.e0;
					ecol_q[1] <= cmd.e1;
					ecol_q[2] <= cmd.e2;
					px_q      <= cmd.lox;
					py_q      <= cmd.loy;
					addr_q    <= cmd.rd_addr;
				end
			end
			ST_SCAN, ST_CMP: begin
				for (int i = 0; i < 3; i++) begin
					w_q[i] <= (e_q[i] < 0) ? AW'(-e_q[i]) : AW'(e_q[i]);
				end
				if (state_q == ST_CMP || !covered) begin
					// advance to the next pixel, column-major
					if (last_row) begin
						px_q <= px_q + DIM_W'(1);
						py_q <= cmd_q.loy;
						for (int i = 0; i < 3; i++) begin
							e_q[i]    <= ecol_q[i] + dxe[i];
							ecol_q[i] <= ecol_q[i] + dxe[i];
						end
					end else begin
						py_q <= py_q + DIM_W'(1);
						for (int i = 0; i < 3; i++) begin
							e_q[i] <= e_q[i] + dye[i];
						end
					end
				end
			end
			ST_MUL: begin
				for (int i = 0; i < 3; i++) begin
					prod_q[i] <= NW'(w_q[i]) * NW'(zc[i]);
				end
				addr_q <= (PIX_W'(eff_h) - PIX_W'(1) - PIX_W'(py_q)) * PIX_W'(eff_w)
					+ PIX_W'(px_q);
			end
			ST_SUM: begin
				rem_q <= AW'(num >> DEPTH_BITS);
				lo_q  <= num[DEPTH_BITS-1:0];
				cnt_q <= '0;
			end
			ST_DIV: begin
				rem_q <= rem_d;
				lo_q  <= lo_q << 1;
				quo_q <= {quo_q[DEPTH_BITS-2:0], div_ge};
				cnt_q <= cnt_q + CNT_W'(1);
			end
			ST_ROUT: begin
				if (slot_free) begin
					out_c_q <= (cmd_q.rd_ok && addr_ok) ? color_rd : '0;
					out_d_q <= (cmd_q.rd_ok && addr_ok) ? depth_rd : '0;
				end
			end
			default: begin
			end
		endcase
	end

	assign init_done = init_q;
	assign out_valid = out_v_q;
	assign out_color = out_c_q;
	assign out_depth = out_d_q;

endmodule

// ===== hdl/triangle_raster_depth_test_core.sv =====
// Top level of the triangle raster / depth test core: config registers,
// stream unpacking, front end, command queue and back end.
// Depends on trd_pkg, trd_front, trd_queue, trd_back.
//
//  channel  direction  carries                              handshake
//  s_*      in         draw / clear / read items            s_tvalid & s_tready
//  m_*      out        pixel color and depth of a read      m_tvalid & m_tready
//  cfg_*    in         screen width and height registers    cfg_we
//
// A draw only scans past each uncovered pixel of the clipped bounding box and takes
// each covered one through the multiply, sum, bit-serial depth divider and compare states.
// A clear sweeps every store entry, one per cycle; a read result passes the front-end
// stages, the queue, the read-wait and output states when nothing is ahead of it.
// After reset every store entry is swept and no item is taken until the sweep ends.
// A two-entry queue lets the front end keep accepting while the back
// end scans or a read result waits on m_tready.
module triangle_raster_depth_test_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [175:0]      s_tdata,   // x0,y0,z0,x1,y1,z1,x2,y2,z2,fill_color,clear_mask,pad
	input  logic [1:0]        s_tuser,   // kind
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [39:0]       m_tdata,   // pixel_color, pixel_depth
	input  logic              cfg_we,
	input  trd_pkg::reg_idx_t cfg_index,
	input  logic [7:0]        cfg_data
);
	import trd_pkg::*;

	localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;

	logic [DIM_W-1:0] width_q, height_q, eff_w, eff_h;
	item_t            item;
	cmd_t             f_cmd, q_cmd;
	logic             f_ready, f_push, q_full, q_empty, q_pop, init_done;
	logic [COLOR_W-1:0]    out_color;
	logic [DEPTH_BITS-1:0] out_depth;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 8'd128;
			height_q <= 8'd128;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				default:    width_q  <= width_q;
			endcase
		end
	end

	// zero acts as one, large values clamp to the store dimensions
	assign eff_w = (width_q == '0) ? DIM_W'(1) :
		(32'(width_q) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : width_q;
	assign eff_h = (height_q == '0) ? DIM_W'(1) :
		(32'(height_q) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : height_q;

	always_comb begin
		item.kind       = kind_t'(s_tuser);
		item.x0         = s_tdata[15:0];
		item.y0         = s_tdata[31:16];
		item.z0         = s_tdata[47:32];
		item.x1         = s_tdata[63:48];
		item.y1         = s_tdata[79:64];
		item.z1         = s_tdata[95:80];
		item.x2         = s_tdata[111:96];
		item.y2         = s_tdata[127:112];
		item.z2         = s_tdata[143:128];
		item.fill_color = s_tdata[167:144];
		item.clear_mask = s_tdata[169:168];
	end

	assign s_tready = f_ready && init_done;

	trd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.item_valid (s_tvalid && init_done),
		.item_ready (f_ready),
		.eff_w      (eff_w),
		.eff_h      (eff_h),
		.cmd        (f_cmd),
		.cmd_push   (f_push),
		.q_full     (q_full)
	);

	trd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_data (f_cmd),
		.push    (f_push),
		.full    (q_full),
		.rd_data (q_cmd),
		.pop     (q_pop),
		.empty   (q_empty)
	);

	trd_back #(
		.STORE_SIZE (STORE_SIZE)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (q_cmd),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.eff_w     (eff_w),
		.eff_h     (eff_h),
		.init_done (init_done),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_color (out_color),
		.out_depth (out_depth)
	);

	assign m_tdata = {out_depth, out_color};

endmodule
